// File: hw/rtl/gra_pkg.sv
package gra_pkg;
    localparam int MaxFreeRegions = 64;
    localparam int FitWindow      = 10;
    localparam int CoordW         = 13;
    localparam int PosW           = 12;
    localparam int EntryW         = 4 * CoordW;

    typedef logic [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
    } t_rect;

    localparam logic CfgAtlasWidth  = 1'b0;
    localparam logic CfgAtlasHeight = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESTORE,
        S_SCAN,
        S_PICK,
        S_DEL,
        S_SPLIT,
        S_APPEND,
        S_SORT_KEY,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_DONE
    } t_state;
endpackage

// File: hw/rtl/gra_ram.sv
module gra_ram #(
    parameter int Width = 52,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/guillotine_rect_allocator.sv
// Search: table entries are scanned from the last down; the search closes once FIT_WINDOW
// entries, the first fit included, are scanned, then the best is picked; a reset word or
// an empty table skips the scan. Exact fit: the entries after it are shifted down. Split:
// the kept piece is written over the pick, a second one appended if both are non-empty
// and there is room, then an insertion sort. One word in flight; the next is taken once the result is loaded.
// Reset: sync, active low; atlas 256x256, count 1, entry 0 written while reset is held.
module guillotine_rect_allocator
    import gra_pkg::*;
#(
    parameter int MAX_FREE_REGIONS = gra_pkg::MaxFreeRegions,
    parameter int FIT_WINDOW       = gra_pkg::FitWindow
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_mode,
    input  logic [gra_pkg::CoordW-1:0] i_req_width,
    input  logic [gra_pkg::CoordW-1:0] i_req_height,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_found,
    output logic [gra_pkg::PosW-1:0] o_pos_x,
    output logic [gra_pkg::PosW-1:0] o_pos_y,
    output logic                   o_list_overflow,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [gra_pkg::CoordW-1:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_FREE_REGIONS);
    localparam int CW = $clog2(MAX_FREE_REGIONS + 1);
    localparam int BW = $clog2(FIT_WINDOW + 1);
    localparam int PW = CoordW + 3;

    t_state r_state, n_state;
    t_coord r_aw, r_ah;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [BW-1:0] r_budget;
    logic [PW-1:0] r_bper;
    logic [AW-1:0] r_best;
    logic          r_have;
    t_rect         r_src, r_key;
    t_coord        r_rw, r_rh;
    logic          r_ovf;
    logic          r_oval, r_ofound;
    logic [PosW-1:0] r_ox, r_oy;
    logic          r_oovf;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    t_rect           wdata, rd;
    logic [EntryW-1:0] rdata;

    gra_ram #(.Width(EntryW), .Depth(MAX_FREE_REGIONS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );
    assign rd = t_rect'(rdata);

    // split pieces
    t_coord lw, lh;
    t_rect pa, pb, keep, extra;
    logic [2*CoordW-1:0] area_a, area_b;
    logic [PW-1:0] per;
    logic fit;
    always_comb begin
        lw = r_src.w - r_rw;
        lh = r_src.h - r_rh;
        pa.x = r_src.x + r_rw;
        pa.y = r_src.y;
        pa.w = lw;
        pb.x = r_src.x;
        pb.y = r_src.y + r_rh;
        pb.h = lh;
        if (lh > lw) begin
            pa.h = r_rh;
            pb.w = r_src.w;
        end else begin
            pa.h = r_src.h;
            pb.w = r_rw;
        end
        area_a = pa.w * pa.h;
        area_b = pb.w * pb.h;
        keep  = (area_a < area_b) ? pb : pa;
        extra = (area_a < area_b) ? pa : pb;
        per = {2'b0, rd.w, 1'b0} + {2'b0, rd.h, 1'b0};
        fit = (rd.w >= r_rw) && (rd.h >= r_rh);
    end

    logic [CoordW:0] ks, ps;
    assign ks = {1'b0, r_key.w} + {1'b0, r_key.h};
    assign ps = {1'b0, rd.w} + {1'b0, rd.h};

    logic          hit, scan_have, scan_end, exact, del_more, two_piece, room, shift;
    logic [BW-1:0] scan_budget;
    assign hit         = fit && (per < r_bper);
    assign scan_have   = r_have || hit;
    assign scan_budget = scan_have ? r_budget - BW'(1) : r_budget;
    assign scan_end    = (scan_budget == '0) || (r_i == '0);
    assign exact       = (r_src.w == r_rw) && (r_src.h == r_rh);
    assign del_more    = (CW'(r_j) + CW'(1)) < r_cnt;
    assign two_piece   = (area_a != '0) && (area_b != '0);
    assign room        = r_cnt < CW'(MAX_FREE_REGIONS);
    assign shift       = (r_j != '0) && (ps < ks);

    logic in_acc, out_acc, load_out;
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_oval && !i_stall;
    assign load_out = (r_state == S_DONE) && (!r_oval || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_mode) n_state = S_RESTORE;
                    else if (r_cnt == '0) n_state = S_DONE;
                    else n_state = S_SCAN;
                end
            end
            S_RESTORE:   n_state = S_DONE;
            S_SCAN:      if (scan_end) n_state = S_PICK;
            S_PICK: begin
                if (!r_have) n_state = S_DONE;
                else if (exact) n_state = S_DEL;
                else n_state = S_SPLIT;
            end
            S_DEL:       if (!del_more) n_state = S_DONE;
            S_SPLIT:     n_state = (two_piece && room) ? S_APPEND : S_SORT_KEY;
            S_APPEND:    n_state = S_SORT_KEY;
            S_SORT_KEY:  n_state = (r_i >= r_cnt) ? S_DONE : S_SORT_LOAD;
            S_SORT_LOAD: n_state = S_SORT_CMP;
            S_SORT_CMP:  if (!shift) n_state = S_SORT_KEY;
            S_DONE:      if (load_out) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = r_key;
        raddr = '0;
        unique case (r_state)
            S_IDLE: raddr = AW'(r_cnt - CW'(1));
            S_RESTORE: begin
                we = 1'b1;
                wdata = '{x: '0, y: '0, w: r_aw, h: r_ah};
            end
            S_SCAN: raddr = AW'(r_i - CW'(1));
            S_PICK: raddr = r_best + AW'(1);
            S_DEL: begin
                raddr = r_j + AW'(2);
                if (del_more) begin
                    we = 1'b1;
                    waddr = r_j;
                    wdata = rd;
                end
            end
            S_SPLIT: begin
                we = 1'b1;
                waddr = r_best;
                wdata = (area_a == '0) ? pb : ((area_b == '0) ? pa : keep);
            end
            S_APPEND: begin
                we = 1'b1;
                waddr = AW'(r_cnt);
                wdata = extra;
            end
            S_SORT_KEY:  raddr = AW'(r_i);
            S_SORT_LOAD: raddr = AW'(r_i - CW'(1));
            S_SORT_CMP: begin
                // shift the lighter entry up, or drop the key into its slot
                raddr = r_j - AW'(2);
                we = 1'b1;
                waddr = r_j;
                wdata = shift ? rd : r_key;
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            we = 1'b1;
            waddr = '0;
            wdata = '{x: '0, y: '0, w: t_coord'(256), h: t_coord'(256)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_aw     <= t_coord'(256);
            r_ah     <= t_coord'(256);
            r_cnt    <= CW'(1);
            r_oval   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CfgAtlasWidth)  r_aw <= i_cfg_data;
                if (i_cfg_index == CfgAtlasHeight) r_ah <= i_cfg_data;
            end
            if (load_out) r_oval <= 1'b1;
            else if (out_acc) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_rw <= i_req_width;
                    r_rh <= i_req_height;
                    r_i  <= r_cnt - CW'(1);
                    r_have <= 1'b0;
                    r_ovf <= 1'b0;
                    r_budget <= BW'(FIT_WINDOW);
                    r_bper <= {2'b0, r_aw, 1'b0} + {2'b0, r_ah, 1'b0} + PW'(1);
                end
                S_RESTORE: r_cnt <= CW'(1);
                S_SCAN: begin
                    if (hit) begin
                        r_bper <= per;
                        r_best <= AW'(r_i);
                        r_src  <= rd;
                    end
                    r_have   <= scan_have;
                    r_budget <= scan_budget;
                    r_i      <= r_i - CW'(1);
                end
                S_PICK: r_j <= r_best;
                S_DEL: begin
                    if (del_more) r_j <= r_j + AW'(1);
                    else r_cnt <= r_cnt - CW'(1);
                end
                S_SPLIT: begin
                    if (two_piece && !room) r_ovf <= 1'b1;
                    r_i <= CW'(1);
                end
                S_APPEND: r_cnt <= r_cnt + CW'(1);
                S_SORT_LOAD: begin
                    r_key <= rd;
                    r_j <= AW'(r_i);
                end
                S_SORT_CMP: begin
                    if (shift) r_j <= r_j - AW'(1);
                    else r_i <= r_i + CW'(1);
                end
                S_DONE: if (load_out) begin
                    r_ofound <= r_have;
                    r_ox     <= r_src.x[PosW-1:0];
                    r_oy     <= r_src.y[PosW-1:0];
                    r_oovf   <= r_ovf;
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_oval;
    assign o_found         = r_ofound;
    assign o_pos_x         = r_ofound ? r_ox : '0;
    assign o_pos_y         = r_ofound ? r_oy : '0;
    assign o_list_overflow = r_oovf && r_ofound;
endmodule
